FILE: hdl/linear_waypoint_interpolator_unit_macros.svh
// Assertion macros shared by the waypoint interpolator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef LINEAR_WAYPOINT_INTERPOLATOR_UNIT_MACROS_SVH
`define LINEAR_WAYPOINT_INTERPOLATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LWI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lwi check failed");
`define LWI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lwi check failed");
`else
`define LWI_ASSERT(lbl, clk, rst, prop)
`define LWI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/lwi_pkg.sv
// Package for the waypoint interpolator: constants, shared types and helpers.
// No dependencies; used by every module of the block but lwi_div.
`timescale 1ns / 1ps
package lwi_pkg;

   localparam int MAX_SEG_DEF = 32;

   localparam logic [1:0] CFG_LIN  = 2'd0;
   localparam logic [1:0] CFG_ANG  = 2'd1;
   localparam logic [1:0] CFG_STEP = 2'd2;

   localparam logic [23:0] LIN_RST  = 24'd65536;
   localparam logic [23:0] ANG_RST  = 24'd5898240;
   localparam logic [23:0] STEP_RST = 24'd32768;

   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_PIECE = 2'd1;
   localparam logic [1:0] KIND_TURN  = 2'd2;

   localparam logic [21:0] DEG_PER_RAD = 22'd3754936;
   localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic signed [27:0] PI_Q16 = 28'sd205887;
   localparam logic [39:0] TIME_MAX = 40'hFF_FFFF_FFFF;

   typedef struct packed {
      logic [23:0] lin;
      logic [23:0] ang;
      logic [23:0] step;
   } cfg_type;

   typedef struct packed {
      logic        echo;
      logic        move;
      logic        turn;
      logic        clamp;
      logic [5:0]  n;
      logic [31:0] x1;
      logic [31:0] y1;
      logic [18:0] h1;
      logic [31:0] px;
      logic [31:0] py;
      logic        neg_x;
      logic        neg_y;
      logic [32:0] qx;
      logic [5:0]  rx;
      logic [32:0] qy;
      logic [5:0]  ry;
      logic [18:0] yaw;
      logic [39:0] tacc;
      logic [49:0] qd;
      logic [29:0] rd;
      logic [29:0] den;
      logic [39:0] tfin;
   } job_type;

   function automatic logic [23:0] atan_entry(input logic [4:0] i);
      logic [23:0] v;
      case (i)
         5'd0:    v = 24'd13176795;
         5'd1:    v = 24'd7778716;
         5'd2:    v = 24'd4110060;
         5'd3:    v = 24'd2086331;
         5'd4:    v = 24'd1047214;
         5'd5:    v = 24'd524117;
         5'd6:    v = 24'd262123;
         5'd7:    v = 24'd131069;
         5'd8:    v = 24'd65536;
         5'd9:    v = 24'd32768;
         5'd10:   v = 24'd16384;
         5'd11:   v = 24'd8192;
         5'd12:   v = 24'd4096;
         5'd13:   v = 24'd2048;
         5'd14:   v = 24'd1024;
         5'd15:   v = 24'd512;
         5'd16:   v = 24'd256;
         5'd17:   v = 24'd128;
         5'd18:   v = 24'd64;
         5'd19:   v = 24'd32;
         5'd20:   v = 24'd16;
         5'd21:   v = 24'd8;
         5'd22:   v = 24'd4;
         5'd23:   v = 24'd2;
         default: v = 24'd0;
      endcase
      return v;
   endfunction

   function automatic logic [39:0] sat_add(input logic [39:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {25'd0, a} + {1'b0, b};
      return (s > {25'd0, TIME_MAX}) ? TIME_MAX : s[39:0];
   endfunction

endpackage

FILE: hdl/linear_waypoint_interpolator_unit.sv
// Linear waypoint interpolator, top level: setting registers, front end,
// job queue and back end. Uses lwi_pkg, lwi_front, lwi_queue, lwi_back.
//
// Waypoints enter on the req_ channel (valid/stall); poses leave on rsp_.
// A waypoint with req_first set (or the first after reset) gives one start
// echo. Each later waypoint gives up to MAX_SEGMENTS piece transactions and
// at most one turn transaction; rsp_last marks the final one of a waypoint.
// Settings (lin_speed, ang_speed, max_step) are written on csr_ at any time
// csr_ready is high; write them only while the block is idle.
// Front end: a moving waypoint runs a bit-serial square root, a CORDIC and
// up to six serial divisions; a start echo or a pure turn is far shorter.
// req_stall is high for this whole time.
// Back end: one transaction per cycle from a job unless rsp_ stalls; the
// two-entry queue lets the front end work on the next waypoint as results drain.
// Reset clears the previous waypoint, time base and settings to defaults.
// A stalled rsp_ holds its transaction; the back end and then the queue
// fill up, and the front end stalls req_ at the end of its next waypoint.
`timescale 1ns / 1ps
module linear_waypoint_interpolator_unit #(
   parameter int MAX_SEGMENTS = lwi_pkg::MAX_SEG_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [18:0] req_heading,
   input  logic [39:0] req_start_time,
   input  logic        req_first,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [18:0] rsp_out_heading,
   output logic [39:0] rsp_out_time,
   output logic [1:0]  rsp_point_kind,
   output logic        rsp_last,
   output logic        rsp_clamped
);
   logic [23:0] lin_ff, ang_ff, step_ff;
   lwi_pkg::cfg_type cfg;
   lwi_pkg::job_type push_data, pop_data;
   logic q_push, q_full, q_pop, q_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ff  <= lwi_pkg::LIN_RST;
         ang_ff  <= lwi_pkg::ANG_RST;
         step_ff <= lwi_pkg::STEP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lwi_pkg::CFG_LIN:  lin_ff  <= csr_wdata;
            lwi_pkg::CFG_ANG:  ang_ff  <= csr_wdata;
            lwi_pkg::CFG_STEP: step_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // a zero setting behaves as one
   always_comb begin
      cfg.lin  = (lin_ff == 24'd0) ? 24'd1 : lin_ff;
      cfg.ang  = (ang_ff == 24'd0) ? 24'd1 : ang_ff;
      cfg.step = (step_ff == 24'd0) ? 24'd1 : step_ff;
   end

   lwi_front #(
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_heading    (req_heading),
      .req_start_time (req_start_time),
      .req_first      (req_first),
      .cfg            (cfg),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (push_data)
   );

   lwi_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (push_data),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (pop_data),
      .empty (q_empty)
   );

   lwi_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (pop_data),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_heading (rsp_out_heading),
      .rsp_out_time    (rsp_out_time),
      .rsp_point_kind  (rsp_point_kind),
      .rsp_last        (rsp_last),
      .rsp_clamped     (rsp_clamped)
   );

endmodule

FILE: hdl/lwi_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Uses no package items; instantiated by lwi_front.
`timescale 1ns / 1ps
module lwi_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   rem_sh;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         cnt_in = CNT_W'(NUM_W);
         run_in = 1'b1;
         num_in = num;
         den_in = den;
         rem_in = '0;
      end else if (run_ff) begin
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = num_ff;
   assign rem  = rem_ff;

endmodule

FILE: hdl/lwi_front.sv
// Front end: accepts waypoints, works out distance, heading, piece count,
// time steps and turn time, and queues at most one job per waypoint. Uses lwi_pkg, lwi_div.
`timescale 1ns / 1ps
module lwi_front #(
   parameter int MAX_SEGMENTS = lwi_pkg::MAX_SEG_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [31:0]      req_pos_x,
   input  logic [31:0]      req_pos_y,
   input  logic [18:0]      req_heading,
   input  logic [39:0]      req_start_time,
   input  logic             req_first,
   input  lwi_pkg::cfg_type cfg,
   input  logic             q_full,
   output logic             q_push,
   output lwi_pkg::job_type q_data
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SQX  = 4'd1;
   localparam logic [3:0] ST_SQY  = 4'd2;
   localparam logic [3:0] ST_SQRT = 4'd3;
   localparam logic [3:0] ST_CORD = 4'd4;
   localparam logic [3:0] ST_DIVN = 4'd5;
   localparam logic [3:0] ST_MULD = 4'd6;
   localparam logic [3:0] ST_DIVD = 4'd7;
   localparam logic [3:0] ST_DIVE = 4'd8;
   localparam logic [3:0] ST_DIVX = 4'd9;
   localparam logic [3:0] ST_DIVY = 4'd10;
   localparam logic [3:0] ST_TURN = 4'd11;
   localparam logic [3:0] ST_MULT = 4'd12;
   localparam logic [3:0] ST_DIVT = 4'd13;
   localparam logic [3:0] ST_PUSH = 4'd14;

   localparam logic [5:0] SEG_MAX = 6'(MAX_SEGMENTS);

   logic [3:0]  state_ff, state_in;
   logic [31:0] px_ff, px_in, py_ff, py_in;
   logic [18:0] ph_ff, ph_in;
   logic [39:0] tacc_ff, tacc_in;
   logic        have_ff, have_in;

   logic [31:0] x1_ff, x1_in, y1_ff, y1_in;
   logic [18:0] h1_ff, h1_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [32:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [65:0] sq_ff, sq_in;
   logic [67:0] rad_ff, rad_in;
   logic [33:0] root_ff, root_in;
   logic [35:0] srem_ff, srem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic signed [36:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [27:0] cz_ff, cz_in;
   logic [18:0] yaw_ff, yaw_in;
   logic [5:0]  n_ff, n_in;
   logic        clamp_ff, clamp_in;
   logic [29:0] den_ff, den_in;
   logic [39:0] dn_ff, dn_in;
   logic [49:0] qd_ff, qd_in;
   logic [29:0] rd_ff, rd_in;
   logic [39:0] tmv_ff, tmv_in;
   logic [32:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [5:0]  rx_ff, rx_in, ry_ff, ry_in;
   logic [41:0] tnum_ff, tnum_in;
   logic [39:0] tfin_ff, tfin_in;
   logic        echo_ff, echo_in, move_ff, move_in, turn_ff, turn_in;
   logic        pend_ff, pend_in;

   logic        div_start, div_done;
   logic [63:0] div_num, div_quot;
   logic [31:0] div_den, div_rem;

   logic [32:0] mul_a;
   logic [65:0] sq_prod;
   logic [35:0] rem_sh, trial;
   logic        root_ge;
   logic signed [36:0] xs, ys, dxe, dye;
   logic signed [27:0] cz_nx, zr;
   logic signed [19:0] delta;
   logic [19:0] dabs;
   logic        has_work;

   lwi_div #(
      .NUM_W(64),
      .DEN_W(32)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   always_comb begin
      mul_a   = pend_ff ? ay_ff : ax_ff;
      sq_prod = mul_a * mul_a;
      rem_sh  = {srem_ff[33:0], rad_ff[67:66]};
      trial   = {1'b0, root_ff[32:0], 2'b01};
      root_ge = rem_sh >= trial;
      xs      = cx_ff >>> cnt_ff[4:0];
      ys      = cy_ff >>> cnt_ff[4:0];
      dxe     = {{4{dx_ff[32]}}, dx_ff};
      dye     = {{4{dy_ff[32]}}, dy_ff};
      if (cy_ff > 37'sd0) begin
         cz_nx = cz_ff + $signed({4'd0, lwi_pkg::atan_entry(cnt_ff[4:0])});
      end else begin
         cz_nx = cz_ff - $signed({4'd0, lwi_pkg::atan_entry(cnt_ff[4:0])});
      end
      zr    = (cz_nx + 28'sd128) >>> 8;
      delta = $signed({h1_ff[18], h1_ff}) - $signed({yaw_ff[18], yaw_ff});
      dabs  = delta[19] ? 20'(-delta) : 20'(delta);
      has_work = echo_ff | move_ff | turn_ff;

      div_num = '0;
      div_den = 32'd1;
      case (state_ff)
         ST_DIVN: begin
            div_num = 64'(root_ff) + 64'(cfg.step) - 64'd1;
            div_den = 32'(cfg.step);
         end
         ST_DIVD: begin
            div_num = {14'd0, root_ff, 16'd0};
            div_den = 32'(den_ff);
         end
         ST_DIVE: begin
            div_num = {8'd0, dn_ff, 16'd0} + 64'(den_ff >> 1);
            div_den = 32'(den_ff);
         end
         ST_DIVX: begin
            div_num = 64'(ax_ff);
            div_den = 32'(n_ff);
         end
         ST_DIVY: begin
            div_num = 64'(ay_ff);
            div_den = 32'(n_ff);
         end
         ST_DIVT: begin
            div_num = 64'(tnum_ff) + 64'(cfg.ang >> 1);
            div_den = 32'(cfg.ang);
         end
         default: begin
            div_num = '0;
            div_den = 32'd1;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      px_in = px_ff;  py_in = py_ff;  ph_in = ph_ff;
      tacc_in = tacc_ff;  have_in = have_ff;
      x1_in = x1_ff;  y1_in = y1_ff;  h1_in = h1_ff;
      dx_in = dx_ff;  dy_in = dy_ff;  ax_in = ax_ff;  ay_in = ay_ff;
      sq_in = sq_ff;  rad_in = rad_ff;  root_in = root_ff;  srem_in = srem_ff;
      cnt_in = cnt_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;  yaw_in = yaw_ff;
      n_in = n_ff;  clamp_in = clamp_ff;  den_in = den_ff;  dn_in = dn_ff;
      qd_in = qd_ff;  rd_in = rd_ff;  tmv_in = tmv_ff;
      qx_in = qx_ff;  rx_in = rx_ff;  qy_in = qy_ff;  ry_in = ry_ff;
      tnum_in = tnum_ff;  tfin_in = tfin_ff;
      echo_in = echo_ff;  move_in = move_ff;  turn_in = turn_ff;
      pend_in = pend_ff;
      div_start = 1'b0;
      q_push = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x1_in = req_pos_x;
               y1_in = req_pos_y;
               h1_in = req_heading;
               dx_in = $signed({req_pos_x[31], req_pos_x}) - $signed({px_ff[31], px_ff});
               dy_in = $signed({req_pos_y[31], req_pos_y}) - $signed({py_ff[31], py_ff});
               echo_in  = 1'b0;
               move_in  = 1'b0;
               turn_in  = 1'b0;
               clamp_in = 1'b0;
               n_in     = '0;
               if (req_first || !have_ff) begin
                  echo_in  = 1'b1;
                  tfin_in  = req_first ? req_start_time : tacc_ff;
                  state_in = ST_PUSH;
               end else if (dx_in != 33'sd0 || dy_in != 33'sd0) begin
                  move_in  = 1'b1;
                  state_in = ST_SQX;
               end else begin
                  yaw_in   = ph_ff;
                  tmv_in   = tacc_ff;
                  state_in = ST_TURN;
               end
            end
         end
         ST_SQX: begin
            ax_in = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
            ay_in = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            if (pend_ff) begin
               rad_in   = {1'b0, 67'(sq_ff) + 67'(sq_prod)};
               root_in  = '0;
               srem_in  = '0;
               cnt_in   = 6'd34;
               pend_in  = 1'b0;
               state_in = ST_SQRT;
            end else begin
               sq_in   = sq_prod;
               pend_in = 1'b1;
            end
         end
         ST_SQRT: begin
            srem_in = root_ge ? 36'(rem_sh - trial) : rem_sh;
            root_in = {root_ff[32:0], root_ge};
            rad_in  = {rad_ff[65:0], 2'b00};
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               cnt_in = '0;
               if (dx_ff[32]) begin
                  if (!dy_ff[32]) begin
                     cx_in = dye;
                     cy_in = -dxe;
                     cz_in = lwi_pkg::HALF_PI_Q24;
                  end else begin
                     cx_in = -dye;
                     cy_in = dxe;
                     cz_in = -lwi_pkg::HALF_PI_Q24;
                  end
               end else begin
                  cx_in = dxe;
                  cy_in = dye;
                  cz_in = 28'sd0;
               end
               state_in = ST_CORD;
            end
         end
         ST_CORD: begin
            if (cy_ff > 37'sd0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
            end
            cz_in  = cz_nx;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd23) begin
               if (zr > lwi_pkg::PI_Q16) begin
                  yaw_in = lwi_pkg::PI_Q16[18:0];
               end else if (zr < -lwi_pkg::PI_Q16) begin
                  yaw_in = 19'(-lwi_pkg::PI_Q16);
               end else begin
                  yaw_in = zr[18:0];
               end
               state_in = ST_DIVN;
            end
         end
         ST_DIVN: begin
            if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               pend_in = 1'b0;
               if (div_quot > 64'(SEG_MAX)) begin
                  n_in     = SEG_MAX;
                  clamp_in = 1'b1;
               end else if (div_quot == 64'd0) begin
                  n_in = 6'd1;
               end else begin
                  n_in = div_quot[5:0];
               end
               state_in = ST_MULD;
            end
         end
         ST_MULD: begin
            den_in   = n_ff * cfg.lin;
            dn_in    = root_ff * n_ff;
            state_in = ST_DIVD;
         end
         ST_DIVD: begin
            if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               pend_in  = 1'b0;
               qd_in    = div_quot[49:0];
               rd_in    = div_rem[29:0];
               state_in = ST_DIVE;
            end
         end
         ST_DIVE: begin
            if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               pend_in  = 1'b0;
               tmv_in   = lwi_pkg::sat_add(tacc_ff, div_quot);
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               pend_in  = 1'b0;
               qx_in    = div_quot[32:0];
               rx_in    = div_rem[5:0];
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               pend_in  = 1'b0;
               qy_in    = div_quot[32:0];
               ry_in    = div_rem[5:0];
               state_in = ST_TURN;
            end
         end
         ST_TURN: begin
            tfin_in = tmv_ff;
            if (dabs != 20'd0) begin
               turn_in  = 1'b1;
               state_in = ST_MULT;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_MULT: begin
            tnum_in  = dabs * lwi_pkg::DEG_PER_RAD;
            state_in = ST_DIVT;
         end
         ST_DIVT: begin
            if (!pend_ff) begin
               div_start = 1'b1;
               pend_in   = 1'b1;
            end else if (div_done) begin
               pend_in  = 1'b0;
               tfin_in  = lwi_pkg::sat_add(tmv_ff, div_quot);
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!q_full || !has_work) begin
               q_push   = has_work;
               px_in    = x1_ff;
               py_in    = y1_ff;
               ph_in    = h1_ff;
               tacc_in  = tfin_ff;
               have_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      q_data.echo  = echo_ff;
      q_data.move  = move_ff;
      q_data.turn  = turn_ff;
      q_data.clamp = clamp_ff;
      q_data.n     = n_ff;
      q_data.x1    = x1_ff;
      q_data.y1    = y1_ff;
      q_data.h1    = h1_ff;
      q_data.px    = px_ff;
      q_data.py    = py_ff;
      q_data.neg_x = dx_ff[32];
      q_data.neg_y = dy_ff[32];
      q_data.qx    = qx_ff;
      q_data.rx    = rx_ff;
      q_data.qy    = qy_ff;
      q_data.ry    = ry_ff;
      q_data.yaw   = yaw_ff;
      q_data.tacc  = tacc_ff;
      q_data.qd    = qd_ff;
      q_data.rd    = rd_ff;
      q_data.den   = den_ff;
      q_data.tfin  = tfin_ff;
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         px_ff    <= '0;
         py_ff    <= '0;
         ph_ff    <= '0;
         tacc_ff  <= '0;
         have_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         ph_ff    <= ph_in;
         tacc_ff  <= tacc_in;
         have_ff  <= have_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= x1_in;  y1_ff <= y1_in;  h1_ff <= h1_in;
      dx_ff <= dx_in;  dy_ff <= dy_in;  ax_ff <= ax_in;  ay_ff <= ay_in;
      sq_ff <= sq_in;  rad_ff <= rad_in;  root_ff <= root_in;  srem_ff <= srem_in;
      cnt_ff <= cnt_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  cz_ff <= cz_in;  yaw_ff <= yaw_in;
      n_ff <= n_in;  clamp_ff <= clamp_in;  den_ff <= den_in;  dn_ff <= dn_in;
      qd_ff <= qd_in;  rd_ff <= rd_in;  tmv_ff <= tmv_in;
      qx_ff <= qx_in;  rx_ff <= rx_in;  qy_ff <= qy_in;  ry_ff <= ry_in;
      tnum_ff <= tnum_in;  tfin_ff <= tfin_in;
      echo_ff <= echo_in;  move_ff <= move_in;  turn_ff <= turn_in;
   end

endmodule

FILE: hdl/lwi_queue.sv
// Two-entry job queue between front and back end.
// Uses lwi_pkg::job_type and the assertion macros.
`timescale 1ns / 1ps
`include "linear_waypoint_interpolator_unit_macros.svh"
module lwi_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lwi_pkg::job_type wdata,
   output logic             full,
   input  logic             pop,
   output lwi_pkg::job_type rdata,
   output logic             empty
);
   lwi_pkg::job_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

   `LWI_ASSERT(a_q_no_overflow, clock, reset, !(push && full))
   `LWI_ASSERT(a_q_no_underflow, clock, reset, !(pop && empty))

endmodule

FILE: hdl/lwi_back.sv
// Back end: expands a queued job into start, piece and turn transactions
// through an output register. Uses lwi_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "linear_waypoint_interpolator_unit_macros.svh"
module lwi_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  lwi_pkg::job_type q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [31:0]      rsp_out_x,
   output logic [31:0]      rsp_out_y,
   output logic [18:0]      rsp_out_heading,
   output logic [39:0]      rsp_out_time,
   output logic [1:0]       rsp_point_kind,
   output logic             rsp_last,
   output logic             rsp_clamped
);
   localparam logic [1:0] PH_ECHO  = 2'd0;
   localparam logic [1:0] PH_PIECE = 2'd1;
   localparam logic [1:0] PH_TURN  = 2'd2;

   lwi_pkg::job_type job_ff, job_in;
   logic        active_ff, active_in;
   logic [1:0]  phase_ff, phase_in;
   logic [5:0]  k_ff, k_in;
   logic [32:0] xq_ff, xq_in, yq_ff, yq_in;
   logic [5:0]  xr_ff, xr_in, yr_ff, yr_in;
   logic [56:0] tq_ff, tq_in;
   logic [29:0] tr_ff, tr_in;
   logic        vld_ff, vld_in;
   logic [31:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [18:0] oh_ff, oh_in;
   logic [39:0] ot_ff, ot_in;
   logic [1:0]  ok_ff, ok_in;
   logic        ol_ff, ol_in, oc_ff, oc_in;

   logic        load;
   logic [6:0]  xr_s, yr_s;
   logic        xc, yc, tc;
   logic [30:0] tr_s;
   logic [32:0] xq_n, yq_n;
   logic [56:0] tq_n;
   logic [31:0] xm, ym;

   always_comb begin
      load  = active_ff && (!vld_ff || !rsp_stall);
      q_pop = !active_ff && !q_empty;

      xr_s = {1'b0, xr_ff} + {1'b0, job_ff.rx};
      xc   = xr_s >= {1'b0, job_ff.n};
      xq_n = xq_ff + job_ff.qx + 33'(xc);
      yr_s = {1'b0, yr_ff} + {1'b0, job_ff.ry};
      yc   = yr_s >= {1'b0, job_ff.n};
      yq_n = yq_ff + job_ff.qy + 33'(yc);
      tr_s = {1'b0, tr_ff} + {1'b0, job_ff.rd};
      tc   = tr_s >= {1'b0, job_ff.den};
      tq_n = tq_ff + 57'(job_ff.qd) + 57'(tc);
      xm   = job_ff.neg_x ? (~xq_n[31:0] + 32'd1) : xq_n[31:0];
      ym   = job_ff.neg_y ? (~yq_n[31:0] + 32'd1) : yq_n[31:0];

      job_in = job_ff;  active_in = active_ff;  phase_in = phase_ff;  k_in = k_ff;
      xq_in = xq_ff;  xr_in = xr_ff;  yq_in = yq_ff;  yr_in = yr_ff;
      tq_in = tq_ff;  tr_in = tr_ff;
      ox_in = ox_ff;  oy_in = oy_ff;  oh_in = oh_ff;  ot_in = ot_ff;
      ok_in = ok_ff;  ol_in = ol_ff;  oc_in = oc_ff;
      vld_in = vld_ff && rsp_stall;

      if (q_pop) begin
         job_in    = q_data;
         active_in = 1'b1;
         phase_in  = q_data.echo ? PH_ECHO : (q_data.move ? PH_PIECE : PH_TURN);
         k_in      = 6'd1;
         xq_in     = '0;
         xr_in     = q_data.n >> 1;
         yq_in     = '0;
         yr_in     = q_data.n >> 1;
         tq_in     = '0;
         tr_in     = q_data.den >> 1;
      end

      if (load) begin
         vld_in = 1'b1;
         case (phase_ff)
            PH_PIECE: begin
               ox_in = job_ff.px + xm;
               oy_in = job_ff.py + ym;
               oh_in = job_ff.yaw;
               ot_in = lwi_pkg::sat_add(job_ff.tacc, 64'(tq_n));
               ok_in = lwi_pkg::KIND_PIECE;
               oc_in = job_ff.clamp;
               ol_in = (k_ff == job_ff.n) && !job_ff.turn;
               xq_in = xq_n;
               xr_in = xc ? 6'(xr_s - {1'b0, job_ff.n}) : xr_s[5:0];
               yq_in = yq_n;
               yr_in = yc ? 6'(yr_s - {1'b0, job_ff.n}) : yr_s[5:0];
               tq_in = tq_n;
               tr_in = tc ? 30'(tr_s - {1'b0, job_ff.den}) : tr_s[29:0];
               k_in  = k_ff + 6'd1;
               if (k_ff == job_ff.n) begin
                  if (job_ff.turn) begin
                     phase_in = PH_TURN;
                  end else begin
                     active_in = 1'b0;
                  end
               end
            end
            PH_TURN: begin
               ox_in = job_ff.x1;
               oy_in = job_ff.y1;
               oh_in = job_ff.h1;
               ot_in = job_ff.tfin;
               ok_in = lwi_pkg::KIND_TURN;
               oc_in = job_ff.clamp;
               ol_in = 1'b1;
               active_in = 1'b0;
            end
            default: begin
               ox_in = job_ff.x1;
               oy_in = job_ff.y1;
               oh_in = job_ff.h1;
               ot_in = job_ff.tfin;
               ok_in = lwi_pkg::KIND_ECHO;
               oc_in = 1'b0;
               ol_in = 1'b1;
               active_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         vld_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         vld_ff    <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;  phase_ff <= phase_in;  k_ff <= k_in;
      xq_ff <= xq_in;  xr_ff <= xr_in;  yq_ff <= yq_in;  yr_ff <= yr_in;
      tq_ff <= tq_in;  tr_ff <= tr_in;
      ox_ff <= ox_in;  oy_ff <= oy_in;  oh_ff <= oh_in;  ot_ff <= ot_in;
      ok_ff <= ok_in;  ol_ff <= ol_in;  oc_ff <= oc_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_out_x       = ox_ff;
   assign rsp_out_y       = oy_ff;
   assign rsp_out_heading = oh_ff;
   assign rsp_out_time    = ot_ff;
   assign rsp_point_kind  = ok_ff;
   assign rsp_last        = ol_ff;
   assign rsp_clamped     = oc_ff;

   `LWI_ASSERT_IMP(a_k_range, clock, reset, active_ff && (phase_ff == PH_PIECE), (k_ff != 6'd0) && (k_ff <= job_ff.n))

endmodule
